// ----- rtl/osp_pkg.sv -----
// Shared types, widths and constants for the square-path controller.
// Used by the multiplier, sine/cosine, square-root and top-level files.
package osp_pkg;

	// Field and datapath widths fixed by the interface.
	localparam int STAMP_W   = 48;
	localparam int HEAD_W    = 40;
	localparam int TRIG_W    = 34;
	localparam int ERR_W     = 43;
	localparam int MUL_A_W   = 49;
	localparam int MUL_B_W   = 33;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int ROOT_W    = 35;
	localparam int SQRT_IN_W = 2 * ROOT_W;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 31;

	// Angle and gain constants in Q30.
	localparam longint PI_Q30      = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint GAIN_Q30    = 64'sd652032874;

	// Item codes.
	localparam logic CMD_ODOM = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIDE_LENGTH    = 3'd0,
		REG_TURN_ANGLE     = 3'd1,
		REG_LINEAR_GAIN    = 3'd2,
		REG_ANGULAR_GAIN   = 3'd3,
		REG_STOP_TOLERANCE = 3'd4
	} osp_reg_t;

	typedef struct packed {
		logic                     cmd;
		logic [STAMP_W-1:0]       stamp;
		logic signed [31:0]       lin_velocity;
		logic signed [31:0]       ang_velocity;
	} osp_sample_t;

	typedef struct packed {
		logic                     kind;
		logic signed [31:0]       pose_x;
		logic signed [31:0]       pose_y;
		logic signed [HEAD_W-1:0] pose_heading;
		logic signed [31:0]       drive_linear;
		logic signed [31:0]       drive_angular;
		logic                     leg_mode;
	} osp_result_t;

	// Multiplier request and response.
	typedef struct packed {
		logic               start;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} osp_mul_req_t;

	typedef struct packed {
		logic               done;
		logic [MUL_P_W-1:0] p;
	} osp_mul_resp_t;

	// Sine/cosine request and response.
	typedef struct packed {
		logic                     start;
		logic signed [HEAD_W-1:0] heading;
	} osp_sc_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [TRIG_W-1:0] cos_v;
		logic signed [TRIG_W-1:0] sin_v;
	} osp_sc_resp_t;

	// Square-root request and response.
	typedef struct packed {
		logic                 start;
		logic [SQRT_IN_W-1:0] radicand;
	} osp_sqrt_req_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} osp_sqrt_resp_t;

	// Rounds a Q30 constant to the given number of fraction bits.
	function automatic longint frac_of(input longint q30, input int frac);
		return (q30 + (64'sd1 <<< (29 - frac))) >>> (30 - frac);
	endfunction

	// Arctangent of 2^-i in Q30.
	function automatic logic [31:0] atan_q30(input logic [4:0] idx);
		logic [31:0] v;
		unique case (idx)
			5'd0:  v = 32'd843314857;
			5'd1:  v = 32'd497837829;
			5'd2:  v = 32'd263043837;
			5'd3:  v = 32'd133525159;
			5'd4:  v = 32'd67021687;
			5'd5:  v = 32'd33543516;
			5'd6:  v = 32'd16775851;
			5'd7:  v = 32'd8388437;
			5'd8:  v = 32'd4194283;
			5'd9:  v = 32'd2097149;
			5'd10: v = 32'd1048576;
			5'd11: v = 32'd524288;
			5'd12: v = 32'd262144;
			5'd13: v = 32'd131072;
			5'd14: v = 32'd65536;
			5'd15: v = 32'd32768;
			5'd16: v = 32'd16384;
			5'd17: v = 32'd8192;
			5'd18: v = 32'd4096;
			5'd19: v = 32'd2048;
			5'd20: v = 32'd1024;
			5'd21: v = 32'd512;
			5'd22: v = 32'd256;
			5'd23: v = 32'd128;
			5'd24: v = 32'd64;
			5'd25: v = 32'd32;
			5'd26: v = 32'd16;
			5'd27: v = 32'd8;
			5'd28: v = 32'd4;
			5'd29: v = 32'd2;
			5'd30: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/osp_mul.sv -----
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on osp_pkg for widths and the request/response structs.
module osp_mul import osp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  osp_mul_req_t  req,
	output osp_mul_resp_t resp
);

	localparam int CW = $clog2(MUL_B_W + 1);

	logic [MUL_A_W-1:0] a_q;
	logic [MUL_A_W-1:0] hi_q;
	logic [MUL_B_W-1:0] lo_q;
	logic [CW-1:0]      cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [MUL_A_W:0]   sum;

	// Add the multiplicand when the low bit of the multiplier is set.
	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

	// Step register: shift the partial product right one bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (req.start) begin
					a_q    <= req.a;
					hi_q   <= '0;
					lo_q   <= req.b;
					cnt_q  <= '0;
					busy_q <= 1'b1;
				end
			end else begin
				hi_q <= sum[MUL_A_W:1];
				lo_q <= {sum[0], lo_q[MUL_B_W-1:1]};
				if (cnt_q == CW'(MUL_B_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	assign resp.done = done_q;
	assign resp.p    = {hi_q, lo_q};

endmodule

// ----- rtl/osp_sincos.sv -----
// Heading reduction and iterative CORDIC for cosine and sine in Q30.
// Depends on osp_pkg for the angle table, constants and structs.
module osp_sincos import osp_pkg::*; #(
	parameter int FRAC_BITS    = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  osp_sc_req_t  req,
	output osp_sc_resp_t resp
);

	localparam int     RW     = FRAC_BITS + 4;
	localparam int     ZSH    = 30 - FRAC_BITS;
	localparam int     CW     = $clog2((HEAD_W > CORDIC_STEPS) ? HEAD_W : CORDIC_STEPS);
	localparam longint PI_L   = frac_of(PI_Q30, FRAC_BITS);
	localparam longint HALF_L = frac_of(HALF_PI_Q30, FRAC_BITS);
	localparam logic [RW-1:0]        TWO_U  = RW'(2 * PI_L);
	localparam logic signed [RW:0]   PI_S   = (RW + 1)'(PI_L);
	localparam logic signed [RW:0]   HALF_S = (RW + 1)'(HALF_L);
	localparam logic signed [RW:0]   TWO_S  = (RW + 1)'(2 * PI_L);

	typedef enum logic [1:0] {SC_IDLE, SC_MOD, SC_FOLD, SC_ITER} sc_state_t;

	sc_state_t                state_q;
	logic [HEAD_W-1:0]        mag_q;
	logic                     neg_q;
	logic [RW-1:0]            rem_q;
	logic [CW-1:0]            cnt_q;
	logic                     flip_q;
	logic                     done_q;
	logic signed [TRIG_W-1:0] x_q;
	logic signed [TRIG_W-1:0] y_q;
	logic signed [TRIG_W-1:0] z_q;

	logic [RW:0]              rem_t;
	logic [RW-1:0]            rem_d;
	logic [RW-1:0]            r0;
	logic signed [RW:0]       r1;
	logic signed [RW:0]       r2;
	logic                     flip_d;
	logic signed [TRIG_W-1:0] z0;
	logic signed [TRIG_W-1:0] dx;
	logic signed [TRIG_W-1:0] dy;
	logic signed [TRIG_W-1:0] at;

	// One bit of the remainder by two pi per cycle.
	always_comb begin
		rem_t = {rem_q, mag_q[HEAD_W-1]};
		if (rem_t >= {1'b0, TWO_U}) begin
			rem_d = RW'(rem_t - {1'b0, TWO_U});
		end else begin
			rem_d = rem_t[RW-1:0];
		end
	end

	// Fold the reduced angle into the right half plane.
	always_comb begin
		r0 = (neg_q && (rem_q != '0)) ? (TWO_U - rem_q) : rem_q;
		r1 = $signed({1'b0, r0});
		if (r1 > PI_S) begin
			r1 = r1 - TWO_S;
		end
		flip_d = 1'b0;
		r2     = r1;
		if (r1 > HALF_S) begin
			r2     = r1 - PI_S;
			flip_d = 1'b1;
		end else if (r1 < -HALF_S) begin
			r2     = r1 + PI_S;
			flip_d = 1'b1;
		end
		z0 = TRIG_W'(r2) <<< ZSH;
	end

	// Shifted terms of the current rotation.
	assign dx = y_q >>> cnt_q[4:0];
	assign dy = x_q >>> cnt_q[4:0];
	assign at = $signed(TRIG_W'(atan_q30(cnt_q[4:0])));

	// Sequencer: reduction, fold, then the rotations.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				SC_IDLE: begin
					if (req.start) begin
						mag_q   <= req.heading[HEAD_W-1] ? HEAD_W'(-req.heading)
						                                 : req.heading;
						neg_q   <= req.heading[HEAD_W-1];
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= SC_MOD;
					end
				end
				SC_MOD: begin
					rem_q <= rem_d;
					mag_q <= {mag_q[HEAD_W-2:0], 1'b0};
					if (cnt_q == CW'(HEAD_W - 1)) begin
						cnt_q   <= '0;
						state_q <= SC_FOLD;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				SC_FOLD: begin
					z_q     <= z0;
					x_q     <= TRIG_W'(GAIN_Q30);
					y_q     <= '0;
					flip_q  <= flip_d;
					state_q <= SC_ITER;
				end
				SC_ITER: begin
					if (z_q >= 0) begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - at;
					end else begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + at;
					end
					if (cnt_q == CW'(CORDIC_STEPS - 1)) begin
						cnt_q   <= '0;
						done_q  <= 1'b1;
						state_q <= SC_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: state_q <= SC_IDLE;
			endcase
		end
	end

	assign resp.done  = done_q;
	assign resp.cos_v = flip_q ? -x_q : x_q;
	assign resp.sin_v = flip_q ? -y_q : y_q;

endmodule

// ----- rtl/osp_isqrt.sv -----
// Digit-by-digit floor square root, one result bit per cycle.
// Depends on osp_pkg for widths and the request/response structs.
module osp_isqrt import osp_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  osp_sqrt_req_t  req,
	output osp_sqrt_resp_t resp
);

	localparam int RMW = ROOT_W + 2;
	localparam int CW  = $clog2(ROOT_W + 1);

	logic [SQRT_IN_W-1:0] rad_q;
	logic [RMW-1:0]       rem_q;
	logic [ROOT_W-1:0]    res_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [RMW+1:0]       rem_t;
	logic [RMW+1:0]       trial;

	// Bring down two radicand bits and try a one in the next root bit.
	assign rem_t = {rem_q, rad_q[SQRT_IN_W-1:SQRT_IN_W-2]};
	assign trial = (RMW + 2)'({res_q, 2'b01});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (req.start) begin
					rad_q  <= req.radicand;
					rem_q  <= '0;
					res_q  <= '0;
					cnt_q  <= '0;
					busy_q <= 1'b1;
				end
			end else begin
				rad_q <= {rad_q[SQRT_IN_W-3:0], 2'b00};
				if (rem_t >= trial) begin
					rem_q <= RMW'(rem_t - trial);
					res_q <= {res_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q <= RMW'(rem_t);
					res_q <= {res_q[ROOT_W-2:0], 1'b0};
				end
				if (cnt_q == CW'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	assign resp.done = done_q;
	assign resp.root = res_q;

endmodule

// ----- rtl/odometry_square_path_controller.sv -----
// Top level of the square-path controller: sequencer, pose and leg state.
// Depends on osp_pkg, osp_mul, osp_sincos and osp_isqrt.
//
// One item is processed at a time; results leave through an output register, so
// the next item is taken while a result waits. Every product goes through one
// bit-serial multiplier. An odometry sample takes four multiplier products plus
// the heading reduction and CORDIC, plus the steps to accept the sample and to
// hand over the result. A control tick in forward mode takes two squares, a
// square root and one gain product; in turn mode only the gain product. A tick
// that ends a leg skips the gain product. There is no clearing pass.
module odometry_square_path_controller import osp_pkg::*; #(
	parameter int FRAC_BITS    = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  osp_sample_t          sample,
	output logic                 result_valid,
	input  logic                 result_stall,
	output osp_result_t          result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int PW = MUL_P_W + 1;
	localparam logic [PW-1:0]        HALF_U  = PW'(1) << (FRAC_BITS - 1);
	localparam logic signed [PW-1:0] HALF_S  = $signed(HALF_U);
	localparam logic signed [PW-1:0] RND30   = $signed(PW'(1) << 29);
	localparam logic signed [PW-1:0] S32_HI  = PW'(32'sh7FFF_FFFF);
	localparam logic signed [PW-1:0] S32_LO  = ~S32_HI;
	localparam logic signed [HEAD_W+1:0] S40_HI = (HEAD_W + 2)'(40'sh7F_FFFF_FFFF);
	localparam logic signed [HEAD_W+1:0] S40_LO = ~S40_HI;

	typedef enum logic [3:0] {
		ST_IDLE, ST_HEAD, ST_RUN, ST_TRIG, ST_POSX, ST_POSY,
		ST_DX, ST_DY, ST_ROOT, ST_TURN, ST_DRIVE, ST_DONE
	} ctl_state_t;

	ctl_state_t               state_q;
	logic                     launch_q;
	osp_sample_t              item_q;
	osp_result_t              result_q;
	logic                     result_valid_q;

	// Configuration registers.
	logic [30:0]              side_q;
	logic [30:0]              turn_q;
	logic [19:0]              lgain_q;
	logic [19:0]              again_q;
	logic [15:0]              tol_q;

	// Pose and leg state.
	logic signed [31:0]       pos_x_q;
	logic signed [31:0]       pos_y_q;
	logic signed [HEAD_W-1:0] heading_q;
	logic [STAMP_W-1:0]       prev_q;
	logic signed [31:0]       lsx_q;
	logic signed [31:0]       lsy_q;
	logic signed [HEAD_W-1:0] lsh_q;
	logic                     mode_q;

	// Working registers of one item.
	logic signed [31:0]       run_q;
	logic signed [TRIG_W-1:0] cos_q;
	logic signed [TRIG_W-1:0] sin_q;
	logic [2*32+2:0]          sq_q;
	logic signed [ERR_W-1:0]  err_q;
	logic signed [31:0]       dl_q;
	logic signed [31:0]       da_q;
	logic                     mneg_q;

	osp_mul_req_t             mreq_q;
	osp_mul_resp_t            mresp;
	osp_sc_req_t              sreq_q;
	osp_sc_resp_t             sresp;
	osp_sqrt_req_t            qreq_q;
	osp_sqrt_resp_t           qresp;

	logic signed [STAMP_W:0]  dt;
	logic [STAMP_W:0]         dt_mag;
	logic [31:0]              av_mag;
	logic [31:0]              lv_mag;
	logic [31:0]              run_mag;
	logic [TRIG_W-1:0]        cos_mag;
	logic [TRIG_W-1:0]        sin_mag;
	logic signed [32:0]       dx;
	logic signed [32:0]       dy;
	logic [32:0]              dx_mag;
	logic [32:0]              dy_mag;
	logic [ERR_W-1:0]         err_mag;
	logic signed [ERR_W-1:0]  tol_s;
	logic signed [ERR_W-1:0]  ferr;
	logic signed [ERR_W-1:0]  terr;

	logic [PW-1:0]            pr;
	logic [PW-1:0]            qv;
	logic [HEAD_W:0]          lim40;
	logic [HEAD_W:0]          qs40;
	logic signed [HEAD_W:0]   mdt40;
	logic [32:0]              lim32;
	logic [32:0]              qs32;
	logic signed [32:0]       mdt32;
	logic signed [HEAD_W+1:0] hsum;
	logic signed [HEAD_W-1:0] head_next;
	logic signed [PW-1:0]     sp;
	logic signed [PW-1:0]     psum;
	logic signed [31:0]       pos_next;
	logic signed [31:0]       drv_next;

	// Saturates a wide signed value to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
		logic signed [31:0] r;
		if (v > S32_HI) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < S32_LO) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	osp_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq_q),
		.resp   (mresp)
	);

	osp_sincos #(
		.FRAC_BITS    (FRAC_BITS),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_sincos (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sreq_q),
		.resp   (sresp)
	);

	osp_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (qreq_q),
		.resp   (qresp)
	);

	// Operand magnitudes and errors.
	always_comb begin
		dt      = $signed({1'b0, item_q.stamp}) - $signed({1'b0, prev_q});
		dt_mag  = dt[STAMP_W] ? (STAMP_W + 1)'(-dt) : dt;
		av_mag  = item_q.ang_velocity[31] ? 32'(-item_q.ang_velocity) : item_q.ang_velocity;
		lv_mag  = item_q.lin_velocity[31] ? 32'(-item_q.lin_velocity) : item_q.lin_velocity;
		run_mag = run_q[31] ? 32'(-run_q) : run_q;
		cos_mag = cos_q[TRIG_W-1] ? TRIG_W'(-cos_q) : cos_q;
		sin_mag = sin_q[TRIG_W-1] ? TRIG_W'(-sin_q) : sin_q;
		dx      = 33'(pos_x_q) - 33'(lsx_q);
		dy      = 33'(pos_y_q) - 33'(lsy_q);
		dx_mag  = dx[32] ? 33'(-dx) : dx;
		dy_mag  = dy[32] ? 33'(-dy) : dy;
		err_mag = err_q[ERR_W-1] ? ERR_W'(-err_q) : err_q;
		tol_s   = $signed(ERR_W'(tol_q));
		ferr    = $signed(ERR_W'(side_q)) - $signed(ERR_W'(qresp.root));
		terr    = $signed(ERR_W'(turn_q)) - (ERR_W'(heading_q) - ERR_W'(lsh_q));
	end

	// Time products: round half away from zero on the magnitude, then saturate.
	always_comb begin
		pr    = {1'b0, mresp.p} + HALF_U;
		qv    = pr >> FRAC_BITS;
		lim40 = {1'b0, {HEAD_W{1'b1}} >> 1} + (HEAD_W + 1)'(mneg_q);
		qs40  = (qv > PW'(lim40)) ? lim40 : qv[HEAD_W:0];
		mdt40 = mneg_q ? -$signed(qs40) : $signed(qs40);
		lim32 = 33'h0_7FFF_FFFF + 33'(mneg_q);
		qs32  = (qv > PW'(lim32)) ? lim32 : qv[32:0];
		mdt32 = mneg_q ? -$signed(qs32) : $signed(qs32);
		hsum  = (HEAD_W + 2)'(heading_q) + (HEAD_W + 2)'(mdt40);
		if (hsum > S40_HI) begin
			head_next = S40_HI[HEAD_W-1:0];
		end else if (hsum < S40_LO) begin
			head_next = S40_LO[HEAD_W-1:0];
		end else begin
			head_next = hsum[HEAD_W-1:0];
		end
	end

	// Signed products for position and drive, rounded half up.
	always_comb begin
		sp       = mneg_q ? -$signed({1'b0, mresp.p}) : $signed({1'b0, mresp.p});
		psum     = ((sp + RND30) >>> 30) +
		           PW'((state_q == ST_POSX) ? pos_x_q : pos_y_q);
		pos_next = sat32(psum);
		drv_next = sat32((sp + HALF_S) >>> FRAC_BITS);
	end

	// Sequencer, state registers, configuration and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			launch_q       <= 1'b0;
			mreq_q         <= '0;
			sreq_q         <= '0;
			qreq_q         <= '0;
			result_valid_q <= 1'b0;
			side_q         <= 31'd196608;
			turn_q         <= 31'd102941;
			lgain_q        <= 20'd32768;
			again_q        <= 20'd21627;
			tol_q          <= 16'd655;
			pos_x_q        <= '0;
			pos_y_q        <= '0;
			heading_q      <= '0;
			prev_q         <= '0;
			lsx_q          <= '0;
			lsy_q          <= '0;
			lsh_q          <= '0;
			mode_q         <= 1'b0;
		end else begin
			mreq_q.start <= 1'b0;
			sreq_q.start <= 1'b0;
			qreq_q.start <= 1'b0;

			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end

			// Register writes; unknown indexes are ignored.
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_SIDE_LENGTH:    side_q  <= cfg_data;
					REG_TURN_ANGLE:     turn_q  <= cfg_data;
					REG_LINEAR_GAIN:    lgain_q <= cfg_data[19:0];
					REG_ANGULAR_GAIN:   again_q <= cfg_data[19:0];
					REG_STOP_TOLERANCE: tol_q   <= cfg_data[15:0];
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (sample_valid) begin
						item_q   <= sample;
						dl_q     <= '0;
						da_q     <= '0;
						launch_q <= 1'b0;
						if (sample.cmd == CMD_ODOM) begin
							state_q <= ST_HEAD;
						end else if (!mode_q) begin
							state_q <= ST_DX;
						end else begin
							state_q <= ST_TURN;
						end
					end
				end
				// Heading advance by angular velocity times dt.
				ST_HEAD: begin
					if (!launch_q) begin
						mreq_q.start <= 1'b1;
						mreq_q.a     <= dt_mag;
						mreq_q.b     <= MUL_B_W'(av_mag);
						mneg_q       <= dt[STAMP_W] ^ item_q.ang_velocity[31];
						launch_q     <= 1'b1;
					end else if (mresp.done) begin
						heading_q <= head_next;
						launch_q  <= 1'b0;
						state_q   <= ST_RUN;
					end
				end
				// Run length from linear velocity times dt.
				ST_RUN: begin
					if (!launch_q) begin
						mreq_q.start <= 1'b1;
						mreq_q.a     <= dt_mag;
						mreq_q.b     <= MUL_B_W'(lv_mag);
						mneg_q       <= dt[STAMP_W] ^ item_q.lin_velocity[31];
						launch_q     <= 1'b1;
					end else if (mresp.done) begin
						run_q    <= mdt32[31:0];
						launch_q <= 1'b0;
						state_q  <= ST_TRIG;
					end
				end
				ST_TRIG: begin
					if (!launch_q) begin
						sreq_q.start   <= 1'b1;
						sreq_q.heading <= heading_q;
						launch_q       <= 1'b1;
					end else if (sresp.done) begin
						cos_q    <= sresp.cos_v;
						sin_q    <= sresp.sin_v;
						launch_q <= 1'b0;
						state_q  <= ST_POSX;
					end
				end
				ST_POSX: begin
					if (!launch_q) begin
						mreq_q.start <= 1'b1;
						mreq_q.a     <= MUL_A_W'(cos_mag);
						mreq_q.b     <= MUL_B_W'(run_mag);
						mneg_q       <= cos_q[TRIG_W-1] ^ run_q[31];
						launch_q     <= 1'b1;
					end else if (mresp.done) begin
						pos_x_q  <= pos_next;
						launch_q <= 1'b0;
						state_q  <= ST_POSY;
					end
				end
				// The y step uses minus sine times the run length.
				ST_POSY: begin
					if (!launch_q) begin
						mreq_q.start <= 1'b1;
						mreq_q.a     <= MUL_A_W'(sin_mag);
						mreq_q.b     <= MUL_B_W'(run_mag);
						mneg_q       <= ~sin_q[TRIG_W-1] ^ run_q[31];
						launch_q     <= 1'b1;
					end else if (mresp.done) begin
						pos_y_q  <= pos_next;
						prev_q   <= item_q.stamp;
						launch_q <= 1'b0;
						state_q  <= ST_DONE;
					end
				end
				ST_DX: begin
					if (!launch_q) begin
						mreq_q.start <= 1'b1;
						mreq_q.a     <= MUL_A_W'(dx_mag);
						mreq_q.b     <= dx_mag;
						launch_q     <= 1'b1;
					end else if (mresp.done) begin
						sq_q     <= 67'(mresp.p[65:0]);
						launch_q <= 1'b0;
						state_q  <= ST_DY;
					end
				end
				ST_DY: begin
					if (!launch_q) begin
						mreq_q.start <= 1'b1;
						mreq_q.a     <= MUL_A_W'(dy_mag);
						mreq_q.b     <= dy_mag;
						launch_q     <= 1'b1;
					end else if (mresp.done) begin
						sq_q     <= sq_q + 67'(mresp.p[65:0]);
						launch_q <= 1'b0;
						state_q  <= ST_ROOT;
					end
				end
				// Distance from the leg start; a short error ends the leg.
				ST_ROOT: begin
					if (!launch_q) begin
						qreq_q.start    <= 1'b1;
						qreq_q.radicand <= SQRT_IN_W'(sq_q);
						launch_q        <= 1'b1;
					end else if (qresp.done) begin
						launch_q <= 1'b0;
						if (ferr < tol_s) begin
							lsx_q   <= pos_x_q;
							lsy_q   <= pos_y_q;
							mode_q  <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							err_q   <= ferr;
							state_q <= ST_DRIVE;
						end
					end
				end
				// Remaining turn angle; a short error ends the turn.
				ST_TURN: begin
					if (terr < tol_s) begin
						lsh_q   <= heading_q;
						mode_q  <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						err_q   <= terr;
						state_q <= ST_DRIVE;
					end
				end
				ST_DRIVE: begin
					if (!launch_q) begin
						mreq_q.start <= 1'b1;
						mreq_q.a     <= MUL_A_W'(err_mag);
						mreq_q.b     <= MUL_B_W'(mode_q ? again_q : lgain_q);
						mneg_q       <= err_q[ERR_W-1];
						launch_q     <= 1'b1;
					end else if (mresp.done) begin
						if (mode_q) begin
							da_q <= drv_next;
						end else begin
							dl_q <= drv_next;
						end
						launch_q <= 1'b0;
						state_q  <= ST_DONE;
					end
				end
				// Hand the result to the output register once it is free.
				ST_DONE: begin
					if (!result_valid_q || !result_stall) begin
						result_q.kind          <= item_q.cmd;
						result_q.pose_x        <= pos_x_q;
						result_q.pose_y        <= pos_y_q;
						result_q.pose_heading  <= heading_q;
						result_q.drive_linear  <= dl_q;
						result_q.drive_angular <= da_q;
						result_q.leg_mode      <= mode_q;
						result_valid_q         <= 1'b1;
						state_q                <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign sample_stall = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign cfg_ready    = 1'b1;

endmodule
